// ===== rtl/core/three_axis_stepper_positioner_macros.svh =====
// assertion macros used by the positioner rtl
`ifndef THREE_AXIS_STEPPER_POSITIONER_MACROS_SVH
`define THREE_AXIS_STEPPER_POSITIONER_MACROS_SVH

// property that must hold on every clock edge out of reset
`define TSP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("tsp invariant violated");

// same-cycle implication
`define TSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsp implication violated");

// next-cycle implication
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsp next-cycle implication violated");

`endif

// ===== rtl/core/tsp_pkg.sv =====
// types, constants and helpers for the three-axis stepper positioner
package tsp_pkg;

	localparam int COUNT_BITS = 17;
	localparam int TGT_W      = 9;
	localparam int SPU_W      = 16;
	localparam int PROD_W     = TGT_W + SPU_W;
	localparam int RND_W      = PROD_W - 7;
	localparam int CMP_W      = ((RND_W > COUNT_BITS) ? RND_W : COUNT_BITS) + 1;
	localparam int NUM_MOTORS = 3;

	// per-motor array index
	localparam logic [1:0] IDX_ACCEL   = 2'd0;
	localparam logic [1:0] IDX_DEFLECT = 2'd1;
	localparam logic [1:0] IDX_MAG     = 2'd2;

	// motor_active codes
	localparam logic [1:0] MOT_NONE    = 2'd0;
	localparam logic [1:0] MOT_ACCEL   = 2'd1;
	localparam logic [1:0] MOT_DEFLECT = 2'd2;
	localparam logic [1:0] MOT_MAG     = 2'd3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	localparam logic [1:0] ARC_OFF  = 2'd0;
	localparam logic [1:0] ARC_CW   = 2'd1;
	localparam logic [1:0] ARC_CCW  = 2'd2;
	localparam logic [1:0] ARC_KEEP = 2'd3;

	localparam logic [1:0] POL_OFF  = 2'd0;
	localparam logic [1:0] POL_POS  = 2'd1;
	localparam logic [1:0] POL_NEG  = 2'd2;
	localparam logic [1:0] POL_KEEP = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_ACCEL_SPU     = 3'd0;
	localparam logic [2:0] REG_DEFLECT_SPU   = 3'd1;
	localparam logic [2:0] REG_MAG_SPU       = 3'd2;
	localparam logic [2:0] REG_ACCEL_LIMIT   = 3'd3;
	localparam logic [2:0] REG_DEFLECT_LIMIT = 3'd4;
	localparam logic [2:0] REG_MAG_LIMIT     = 3'd5;

	localparam logic [SPU_W-1:0] RST_ACCEL_SPU     = 16'd3128;
	localparam logic [SPU_W-1:0] RST_DEFLECT_SPU   = 16'd3911;
	localparam logic [SPU_W-1:0] RST_MAG_SPU       = 16'd2607;
	localparam logic [TGT_W-1:0] RST_ACCEL_LIMIT   = 9'd250;
	localparam logic [TGT_W-1:0] RST_DEFLECT_LIMIT = 9'd250;
	localparam logic [TGT_W-1:0] RST_MAG_LIMIT     = 9'd300;
	localparam logic [TGT_W-1:0] RST_DEFLECT_POS   = 9'd50;
	localparam logic [TGT_W-1:0] RST_OTHER_POS     = 9'd0;

	localparam logic [3:0] RELAY_ALL = 4'hF;

	typedef struct packed {
		logic [SPU_W-1:0] accel_spu;
		logic [SPU_W-1:0] deflect_spu;
		logic [SPU_W-1:0] mag_spu;
		logic [TGT_W-1:0] accel_limit;
		logic [TGT_W-1:0] deflect_limit;
		logic [TGT_W-1:0] mag_limit;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [TGT_W-1:0] deflect_target;
		logic [TGT_W-1:0] accel_target;
		logic [TGT_W-1:0] mag_target;
		logic [1:0]       arc_mode;
		logic [1:0]       deflect_polarity;
	} item_t;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic [1:0] motor_active;
		logic [3:0] relay_bits;
		logic       busy;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic                  ok;
		logic                  fwd;
		logic [COUNT_BITS-1:0] count;
	} plan_t;

	// full-step coil pattern for a phase
	function automatic logic [3:0] coil_of(input logic [1:0] ph);
		logic [3:0] c;
		unique case (ph)
			2'd0: c = 4'h3;
			2'd1: c = 4'h6;
			2'd2: c = 4'hC;
			2'd3: c = 4'h9;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/tsp_plan.sv =====
// step count and direction for one motor of a new command
module tsp_plan (
	input  logic [tsp_pkg::TGT_W-1:0] target,
	input  logic [tsp_pkg::TGT_W-1:0] limit,
	input  logic [tsp_pkg::SPU_W-1:0] spu,
	input  logic [tsp_pkg::TGT_W-1:0] pos,
	output tsp_pkg::plan_t            plan
);

	logic                          fwd;
	logic [tsp_pkg::TGT_W-1:0]     diff;
	logic [tsp_pkg::PROD_W-1:0]    prod;
	logic [tsp_pkg::PROD_W:0]      prod_rnd;
	logic [tsp_pkg::CMP_W-1:0]     rnd_w;
	logic [tsp_pkg::CMP_W-1:0]     cnt_max;

	assign fwd      = target > pos;
	assign diff     = fwd ? (target - pos) : (pos - target);
	assign prod     = tsp_pkg::PROD_W'(diff) * tsp_pkg::PROD_W'(spu);
	// round half up, then drop the eight fraction bits
	assign prod_rnd = {1'b0, prod} + (tsp_pkg::PROD_W + 1)'(128);
	assign rnd_w    = tsp_pkg::CMP_W'(prod_rnd[tsp_pkg::PROD_W:8]);
	assign cnt_max  = tsp_pkg::CMP_W'((tsp_pkg::CMP_W'(1) << tsp_pkg::COUNT_BITS) - 1);

	assign plan.ok    = target <= limit;
	assign plan.fwd   = fwd;
	assign plan.count = (rnd_w > cnt_max) ? cnt_max[tsp_pkg::COUNT_BITS-1:0]
	                                      : rnd_w[tsp_pkg::COUNT_BITS-1:0];

endmodule

// ===== rtl/core/tsp_state.sv =====
// motor positions, step counters, relays and the per-word update
`include "three_axis_stepper_positioner_macros.svh"

module tsp_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  tsp_pkg::item_t  item,
	input  tsp_pkg::cfg_t   cfg,
	output tsp_pkg::res_t   res
);

	logic [tsp_pkg::COUNT_BITS-1:0] steps_q [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::COUNT_BITS-1:0] steps_d [tsp_pkg::NUM_MOTORS];
	logic [1:0]                     phase_q [tsp_pkg::NUM_MOTORS];
	logic [1:0]                     phase_d [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::TGT_W-1:0]      pos_q   [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::TGT_W-1:0]      pos_d   [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::TGT_W-1:0]      tgt     [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::TGT_W-1:0]      lim     [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::SPU_W-1:0]      spu     [tsp_pkg::NUM_MOTORS];
	tsp_pkg::plan_t                 plan    [tsp_pkg::NUM_MOTORS];
	logic [tsp_pkg::NUM_MOTORS-1:0] fwd_q, fwd_d;
	logic [3:0]                     relay_now_q, relay_now_d;
	logic [3:0]                     relay_pend_q, relay_pend_d;
	logic                           busy_q, busy_d;
	logic                           sel_hit;
	logic [1:0]                     sel;
	logic [1:0]                     sel_code;

	assign tgt[tsp_pkg::IDX_ACCEL]   = item.accel_target;
	assign tgt[tsp_pkg::IDX_DEFLECT] = item.deflect_target;
	assign tgt[tsp_pkg::IDX_MAG]     = item.mag_target;
	assign lim[tsp_pkg::IDX_ACCEL]   = cfg.accel_limit;
	assign lim[tsp_pkg::IDX_DEFLECT] = cfg.deflect_limit;
	assign lim[tsp_pkg::IDX_MAG]     = cfg.mag_limit;
	assign spu[tsp_pkg::IDX_ACCEL]   = cfg.accel_spu;
	assign spu[tsp_pkg::IDX_DEFLECT] = cfg.deflect_spu;
	assign spu[tsp_pkg::IDX_MAG]     = cfg.mag_spu;

	for (genvar g = 0; g < tsp_pkg::NUM_MOTORS; g++) begin : g_plan
		tsp_plan u_plan (
			.target (tgt[g]),
			.limit  (lim[g]),
			.spu    (spu[g]),
			.pos    (pos_q[g]),
			.plan   (plan[g])
		);
	end

	// deflect first, then accelerate, then magnetize
	always_comb begin
		sel_hit  = 1'b1;
		sel      = tsp_pkg::IDX_DEFLECT;
		sel_code = tsp_pkg::MOT_DEFLECT;
		priority if (steps_q[tsp_pkg::IDX_DEFLECT] != '0) begin
			sel      = tsp_pkg::IDX_DEFLECT;
			sel_code = tsp_pkg::MOT_DEFLECT;
		end else if (steps_q[tsp_pkg::IDX_ACCEL] != '0) begin
			sel      = tsp_pkg::IDX_ACCEL;
			sel_code = tsp_pkg::MOT_ACCEL;
		end else if (steps_q[tsp_pkg::IDX_MAG] != '0) begin
			sel      = tsp_pkg::IDX_MAG;
			sel_code = tsp_pkg::MOT_MAG;
		end else begin
			sel_hit  = 1'b0;
		end
	end

	always_comb begin
		logic pending;
		steps_d      = steps_q;
		phase_d      = phase_q;
		pos_d        = pos_q;
		fwd_d        = fwd_q;
		relay_now_d  = relay_now_q;
		relay_pend_d = relay_pend_q;
		busy_d       = busy_q;
		res          = '0;
		pending      = 1'b0;
		if (item.kind == tsp_pkg::KIND_CMD) begin
			if (busy_q) begin
				res.rejected = 1'b1;
			end else begin
				for (int m = 0; m < tsp_pkg::NUM_MOTORS; m++) begin
					if (plan[m].ok) begin
						steps_d[m] = plan[m].count;
						fwd_d[m]   = plan[m].fwd;
						phase_d[m] = plan[m].fwd ? plan[m].count[1:0] : 2'd0;
						pos_d[m]   = tgt[m];
					end
				end
				unique case (item.arc_mode)
					tsp_pkg::ARC_OFF:  relay_pend_d[1:0] = 2'b11;
					tsp_pkg::ARC_CW:   relay_pend_d[1:0] = 2'b10;
					tsp_pkg::ARC_CCW:  relay_pend_d[1:0] = 2'b01;
					tsp_pkg::ARC_KEEP: relay_pend_d[1:0] = relay_pend_q[1:0];
					default:           relay_pend_d[1:0] = relay_pend_q[1:0];
				endcase
				// negative polarity drives the same levels as off
				unique case (item.deflect_polarity)
					tsp_pkg::POL_OFF:  relay_pend_d[3:2] = 2'b11;
					tsp_pkg::POL_POS:  relay_pend_d[3:2] = 2'b00;
					tsp_pkg::POL_NEG:  relay_pend_d[3:2] = 2'b11;
					tsp_pkg::POL_KEEP: relay_pend_d[3:2] = relay_pend_q[3:2];
					default:           relay_pend_d[3:2] = relay_pend_q[3:2];
				endcase
				for (int m = 0; m < tsp_pkg::NUM_MOTORS; m++) begin
					pending = pending | (steps_d[m] != '0);
				end
				busy_d      = pending;
				relay_now_d = pending ? tsp_pkg::RELAY_ALL : relay_pend_d;
			end
		end else if (busy_q) begin
			if (sel_hit) begin
				res.coil_pattern = tsp_pkg::coil_of(phase_q[sel]);
				res.motor_active = sel_code;
				steps_d[sel]     = steps_q[sel] - 1'b1;
				phase_d[sel]     = fwd_q[sel] ? (phase_q[sel] - 2'd1) : (phase_q[sel] + 2'd1);
			end
			for (int m = 0; m < tsp_pkg::NUM_MOTORS; m++) begin
				pending = pending | (steps_d[m] != '0);
			end
			if (!pending) begin
				busy_d      = 1'b0;
				relay_now_d = relay_pend_q;
			end
		end
		res.relay_bits = relay_now_d;
		res.busy       = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < tsp_pkg::NUM_MOTORS; m++) begin
				steps_q[m] <= '0;
				phase_q[m] <= '0;
			end
			pos_q[tsp_pkg::IDX_ACCEL]   <= tsp_pkg::RST_OTHER_POS;
			pos_q[tsp_pkg::IDX_DEFLECT] <= tsp_pkg::RST_DEFLECT_POS;
			pos_q[tsp_pkg::IDX_MAG]     <= tsp_pkg::RST_OTHER_POS;
			fwd_q        <= '0;
			relay_now_q  <= tsp_pkg::RELAY_ALL;
			relay_pend_q <= tsp_pkg::RELAY_ALL;
			busy_q       <= 1'b0;
		end else if (fire) begin
			steps_q      <= steps_d;
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			fwd_q        <= fwd_d;
			relay_now_q  <= relay_now_d;
			relay_pend_q <= relay_pend_d;
			busy_q       <= busy_d;
		end
	end

	`TSP_ASSERT_ALWAYS(a_busy_matches_steps, clk, arst_n, busy_q == ((steps_q[0] != '0) || (steps_q[1] != '0) || (steps_q[2] != '0)))
	`TSP_ASSERT_IMPL(a_idle_relays_settled, clk, arst_n, !busy_q, relay_now_q == relay_pend_q)
	`TSP_ASSERT_IMPL(a_busy_relays_high, clk, arst_n, busy_q, relay_now_q == tsp_pkg::RELAY_ALL)
	`TSP_ASSERT_NEXT(a_reject_keeps_pos, clk, arst_n, fire && (item.kind == tsp_pkg::KIND_CMD) && busy_q, $stable(pos_q[0]) && $stable(pos_q[1]) && $stable(pos_q[2]))

endmodule

// ===== rtl/core/three_axis_stepper_positioner.sv =====
// top level of the three-axis stepper positioner: handshakes and config registers
//
// usage
//  - input channel (in_valid / in_stall): one word per item, kind 1 is a
//    command with three targets and two relay modes, kind 0 is a step tick
//  - output channel (out_valid / out_stall): exactly one result word per
//    input word, in order: coil pattern, active motor, relay levels, busy
//    flag and command-rejected flag
//  - config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//    ready; write only while no word is in flight
//  - an accepted word goes through the input register and the state update
//    into the result register, which drives out_valid; one word is taken every
//    cycle while the receiver does not stall, as the input register, state update
//    and result register all advance together
//  - when the receiver stalls, the result register holds, the input register
//    fills, and in_stall rises only once both are occupied
//  - reset (arst_n low) clears all motor state, sets the deflect position to
//    50, the relays to all ones, and loads the default config values
module three_axis_stepper_positioner (
	input  logic                        clk,
	input  logic                        arst_n,
	// input word
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [tsp_pkg::TGT_W-1:0]   deflect_target,
	input  logic [tsp_pkg::TGT_W-1:0]   accel_target,
	input  logic [tsp_pkg::TGT_W-1:0]   mag_target,
	input  logic [1:0]                  arc_mode,
	input  logic [1:0]                  deflect_polarity,
	// result word
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  coil_pattern,
	output logic [1:0]                  motor_active,
	output logic [3:0]                  relay_bits,
	output logic                        busy_res,
	output logic                        command_rejected,
	// config writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [tsp_pkg::SPU_W-1:0]   cfg_data
);

	tsp_pkg::cfg_t  cfg_q;
	tsp_pkg::item_t item_s1;
	logic           valid_s1;
	tsp_pkg::res_t  res;
	tsp_pkg::res_t  res_q;
	logic           out_valid_q;
	logic           advance;
	logic           fire;

	// result register free or being emptied this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// config registers, to be written only when idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_spu     <= tsp_pkg::RST_ACCEL_SPU;
			cfg_q.deflect_spu   <= tsp_pkg::RST_DEFLECT_SPU;
			cfg_q.mag_spu       <= tsp_pkg::RST_MAG_SPU;
			cfg_q.accel_limit   <= tsp_pkg::RST_ACCEL_LIMIT;
			cfg_q.deflect_limit <= tsp_pkg::RST_DEFLECT_LIMIT;
			cfg_q.mag_limit     <= tsp_pkg::RST_MAG_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsp_pkg::REG_ACCEL_SPU:     cfg_q.accel_spu     <= cfg_data;
				tsp_pkg::REG_DEFLECT_SPU:   cfg_q.deflect_spu   <= cfg_data;
				tsp_pkg::REG_MAG_SPU:       cfg_q.mag_spu       <= cfg_data;
				tsp_pkg::REG_ACCEL_LIMIT:   cfg_q.accel_limit   <= cfg_data[tsp_pkg::TGT_W-1:0];
				tsp_pkg::REG_DEFLECT_LIMIT: cfg_q.deflect_limit <= cfg_data[tsp_pkg::TGT_W-1:0];
				tsp_pkg::REG_MAG_LIMIT:     cfg_q.mag_limit     <= cfg_data[tsp_pkg::TGT_W-1:0];
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind             <= kind;
			item_s1.deflect_target   <= deflect_target;
			item_s1.accel_target     <= accel_target;
			item_s1.mag_target       <= mag_target;
			item_s1.arc_mode         <= arc_mode;
			item_s1.deflect_polarity <= deflect_polarity;
		end
	end

	// positions, counters and relays; updates on fire
	tsp_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign coil_pattern     = res_q.coil_pattern;
	assign motor_active     = res_q.motor_active;
	assign relay_bits       = res_q.relay_bits;
	assign busy_res         = res_q.busy;
	assign command_rejected = res_q.rejected;

endmodule

// ===== tb/three_axis_stepper_positioner_tb.sv =====
// self-checking testbench for the three-axis stepper positioner
`timescale 1ns / 100ps

module three_axis_stepper_positioner_tb;
	import tsp_pkg::*;

	// cycle limit, far above the slowest correct run with the longest idling
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LEFT_MAX = (1 << COUNT_BITS) - 1;
	// full-step coil patterns, indexed by phase
	localparam logic [3:0][3:0] FULL_STEP = {4'h9, 4'hC, 4'h6, 4'h3};

	// everything the block keeps between words, per motor indexed by IDX_*
	typedef struct packed {
		logic [2:0][TGT_W-1:0]      pos;
		logic [2:0][COUNT_BITS-1:0] left;
		logic [2:0][1:0]            ph;
		logic [2:0]                 fwd;
		logic [3:0]                 relay_out;
		logic [3:0]                 relay_next;
		logic                       busy;
	} axes_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	item_t word_out = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] coil_pattern;
	logic [1:0] motor_active;
	logic [3:0] relay_bits;
	logic busy_res;
	logic command_rejected;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [SPU_W-1:0] cfg_data = '0;

	// settings as last written, shared by both copies of the axes
	cfg_t cfg_now;
	// axes as seen by the stimulus generator (ahead) and by the checker (at acceptance)
	axes_t plan_axes;
	axes_t seen_axes;

	item_t words_to_send[$];
	res_t results_due[$];
	res_t step_guess;
	res_t due_now;

	int unsigned moves_queued;
	int unsigned results_seen;
	int unsigned errors;
	int unsigned cycles;
	int unsigned send_gap;
	int unsigned stall_left;
	bit calm;

	three_axis_stepper_positioner dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (word_out.kind),
		.deflect_target   (word_out.deflect_target),
		.accel_target     (word_out.accel_target),
		.mag_target       (word_out.mag_target),
		.arc_mode         (word_out.arc_mode),
		.deflect_polarity (word_out.deflect_polarity),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.coil_pattern     (coil_pattern),
		.motor_active     (motor_active),
		.relay_bits       (relay_bits),
		.busy_res         (busy_res),
		.command_rejected (command_rejected),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #2 clk = ~clk;

	// what the block must return for one word, moving the axes on by that word
	function automatic res_t advance_axes(inout axes_t s, input item_t w);
		res_t r;
		logic [2:0][TGT_W-1:0] tgt;
		logic [2:0][TGT_W-1:0] lim;
		logic [2:0][SPU_W-1:0] spu;
		logic [2:0][1:0] serve;
		int unsigned gap;
		int unsigned count;
		int m;
		int k;
		bit fwd;
		bit served;
		r = '0;
		if (w.kind == KIND_CMD) begin
			if (s.busy) begin
				// command while moving: dropped, nothing changes
				r.rejected = 1'b1;
			end else begin
				tgt[IDX_ACCEL] = w.accel_target;
				tgt[IDX_DEFLECT] = w.deflect_target;
				tgt[IDX_MAG] = w.mag_target;
				lim[IDX_ACCEL] = cfg_now.accel_limit;
				lim[IDX_DEFLECT] = cfg_now.deflect_limit;
				lim[IDX_MAG] = cfg_now.mag_limit;
				spu[IDX_ACCEL] = cfg_now.accel_spu;
				spu[IDX_DEFLECT] = cfg_now.deflect_spu;
				spu[IDX_MAG] = cfg_now.mag_spu;
				for (m = 0; m < NUM_MOTORS; m++) begin
					// a target beyond the limit leaves that motor alone
					if (tgt[m] <= lim[m]) begin
						fwd = tgt[m] > s.pos[m];
						gap = fwd ? 32'(tgt[m] - s.pos[m]) : 32'(s.pos[m] - tgt[m]);
						// q17.8 product, rounded half up, then clipped to the counter
						count = (gap * 32'(spu[m]) + 128) >> 8;
						if (count > LEFT_MAX)
							count = LEFT_MAX;
						s.left[m] = count[COUNT_BITS-1:0];
						s.fwd[m] = fwd;
						s.ph[m] = fwd ? count[1:0] : 2'd0;
						s.pos[m] = tgt[m];
					end
				end
				case (w.arc_mode)
					ARC_OFF:  s.relay_next[1:0] = 2'b11;
					ARC_CW:   s.relay_next[1:0] = 2'b10;
					ARC_CCW:  s.relay_next[1:0] = 2'b01;
					ARC_KEEP: ;
				endcase
				// negative polarity drives the relays just as off does
				case (w.deflect_polarity)
					POL_OFF, POL_NEG: s.relay_next[3:2] = 2'b11;
					POL_POS:          s.relay_next[3:2] = 2'b00;
					POL_KEEP:         ;
				endcase
				if (s.left != '0) begin
					s.busy = 1'b1;
					s.relay_out = RELAY_ALL;
				end else begin
					s.relay_out = s.relay_next;
				end
			end
		end else if (s.busy) begin
			// deflect first, then accelerate, then magnetise
			serve[0] = IDX_DEFLECT;
			serve[1] = IDX_ACCEL;
			serve[2] = IDX_MAG;
			served = 1'b0;
			for (k = 0; k < NUM_MOTORS; k++) begin
				m = int'(serve[k]);
				if (!served && s.left[m] != '0) begin
					served = 1'b1;
					r.coil_pattern = FULL_STEP[s.ph[m]];
					r.motor_active = (m == int'(IDX_ACCEL)) ? MOT_ACCEL :
						(m == int'(IDX_DEFLECT)) ? MOT_DEFLECT : MOT_MAG;
					s.left[m] = s.left[m] - 1'b1;
					s.ph[m] = s.fwd[m] ? s.ph[m] - 2'd1 : s.ph[m] + 2'd1;
				end
			end
			// the last step already shows the new relay levels
			if (s.left == '0) begin
				s.busy = 1'b0;
				s.relay_out = s.relay_next;
			end
		end
		r.relay_bits = s.relay_out;
		r.busy = s.busy;
		return r;
	endfunction

	function automatic item_t cmd_word(logic [TGT_W-1:0] d, logic [TGT_W-1:0] a,
			logic [TGT_W-1:0] m, logic [1:0] arc, logic [1:0] pol);
		item_t w;
		w.kind = KIND_CMD;
		w.deflect_target = d;
		w.accel_target = a;
		w.mag_target = m;
		w.arc_mode = arc;
		w.deflect_polarity = pol;
		return w;
	endfunction

	// tick with a random payload, which the block must ignore
	function automatic item_t tick_word();
		item_t w;
		w.kind = KIND_TICK;
		w.deflect_target = TGT_W'($urandom_range(0, 511));
		w.accel_target = TGT_W'($urandom_range(0, 511));
		w.mag_target = TGT_W'($urandom_range(0, 511));
		w.arc_mode = 2'($urandom_range(0, 3));
		w.deflect_polarity = 2'($urandom_range(0, 3));
		return w;
	endfunction

	// target for one motor: mostly near moves, some at the edges, cost kept modest
	function automatic logic [TGT_W-1:0] pick_target(logic [TGT_W-1:0] pos,
			logic [TGT_W-1:0] lim, logic [SPU_W-1:0] spu);
		int unsigned reach;
		int unsigned r;
		int d;
		int p;
		int l;
		int t;
		p = int'(pos);
		l = int'(lim);
		reach = (spu == 0) ? 511 : 51200 / 32'(spu);
		if (reach > 511)
			reach = 511;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			t = p;
		end else if (r < 28) begin
			t = (l == 511) ? 511 : l + 1;
		end else if (r < 34) begin
			t = 511;
		end else if (r < 42) begin
			t = l;
		end else if (r < 48) begin
			t = 0;
		end else begin
			d = $urandom_range(0, reach);
			t = ($urandom_range(0, 1) != 0) ? p + d : p - d;
			if (t > 511)
				t = p - d;
			if (t < 0)
				t = p + d;
			if (t < 0 || t > 511)
				t = p;
		end
		// a long accepted move at a steep scale would run for ages
		if (t <= l && ((t > p) ? t - p : p - t) > reach)
			t = p;
		return t[TGT_W-1:0];
	endfunction

	function automatic item_t make_command();
		return cmd_word(
			pick_target(plan_axes.pos[IDX_DEFLECT], cfg_now.deflect_limit, cfg_now.deflect_spu),
			pick_target(plan_axes.pos[IDX_ACCEL], cfg_now.accel_limit, cfg_now.accel_spu),
			pick_target(plan_axes.pos[IDX_MAG], cfg_now.mag_limit, cfg_now.mag_spu),
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
	endfunction

	// queue a word for the driver; only steps and accepted commands count as moves
	task automatic queue_word(input item_t w);
		res_t r;
		r = advance_axes(plan_axes, w);
		words_to_send.push_back(w);
		if (r.motor_active != MOT_NONE || (w.kind == KIND_CMD && !r.rejected))
			moves_queued++;
	endtask

	task automatic tick_until_idle();
		while (plan_axes.busy)
			queue_word(tick_word());
	endtask

	// well-formed moves with some noise: idle ticks and commands sent while busy
	task automatic random_moves(int unsigned quota);
		int unsigned goal;
		goal = moves_queued + quota;
		while (moves_queued < goal) begin
			if (!plan_axes.busy) begin
				if ($urandom_range(0, 5) == 0)
					queue_word(tick_word());
				queue_word(make_command());
			end else if ($urandom_range(0, 24) == 0) begin
				queue_word(make_command());
			end else begin
				queue_word(tick_word());
			end
		end
		tick_until_idle();
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || results_due.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [SPU_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ACCEL_SPU:     cfg_now.accel_spu = data;
			REG_DEFLECT_SPU:   cfg_now.deflect_spu = data;
			REG_MAG_SPU:       cfg_now.mag_spu = data;
			REG_ACCEL_LIMIT:   cfg_now.accel_limit = data[TGT_W-1:0];
			REG_DEFLECT_LIMIT: cfg_now.deflect_limit = data[TGT_W-1:0];
			REG_MAG_LIMIT:     cfg_now.mag_limit = data[TGT_W-1:0];
			default:           ;
		endcase
	endtask

	// limits go out with junk in the upper bits, which the block must drop
	task automatic set_regs(input logic [SPU_W-1:0] a_spu, input logic [SPU_W-1:0] d_spu,
			input logic [SPU_W-1:0] m_spu, input logic [TGT_W-1:0] a_lim,
			input logic [TGT_W-1:0] d_lim, input logic [TGT_W-1:0] m_lim);
		write_reg(REG_ACCEL_SPU, a_spu);
		write_reg(REG_DEFLECT_SPU, d_spu);
		write_reg(REG_MAG_SPU, m_spu);
		write_reg(REG_ACCEL_LIMIT, {7'($urandom_range(0, 127)), a_lim});
		write_reg(REG_DEFLECT_LIMIT, {7'($urandom_range(0, 127)), d_lim});
		write_reg(REG_MAG_LIMIT, {7'($urandom_range(0, 127)), m_lim});
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch in %s at result %0d: got %0d, want %0d",
			what, results_seen, got, want);
		errors++;
	endtask

	// driver: a word stays put until taken; idle bursts only start between words
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			step_guess = advance_axes(seen_axes, words_to_send[0]);
			results_due.push_back(step_guess);
			void'(words_to_send.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (calm) begin
				send_gap = 0;
			end
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 12);
				in_valid <= 1'b0;
			end else if (words_to_send.size() != 0 && arst_n) begin
				in_valid <= 1'b1;
				word_out <= words_to_send[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each taken result word against the oldest one due
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			results_seen++;
			if (results_due.size() == 0) begin
				flag_mismatch("result with nothing due", 0, 0);
			end else begin
				due_now = results_due.pop_front();
				if (coil_pattern !== due_now.coil_pattern)
					flag_mismatch("coil_pattern", 32'(coil_pattern),
						32'(due_now.coil_pattern));
				if (motor_active !== due_now.motor_active)
					flag_mismatch("motor_active", 32'(motor_active),
						32'(due_now.motor_active));
				if (relay_bits !== due_now.relay_bits)
					flag_mismatch("relay_bits", 32'(relay_bits), 32'(due_now.relay_bits));
				if (busy_res !== due_now.busy)
					flag_mismatch("busy_res", 32'(busy_res), 32'(due_now.busy));
				if (command_rejected !== due_now.rejected)
					flag_mismatch("command_rejected", 32'(command_rejected),
						32'(due_now.rejected));
			end
		end
		// receiver stalls in bursts of random length
		if (calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cfg_now.accel_spu = RST_ACCEL_SPU;
		cfg_now.deflect_spu = RST_DEFLECT_SPU;
		cfg_now.mag_spu = RST_MAG_SPU;
		cfg_now.accel_limit = RST_ACCEL_LIMIT;
		cfg_now.deflect_limit = RST_DEFLECT_LIMIT;
		cfg_now.mag_limit = RST_MAG_LIMIT;
		plan_axes = '0;
		plan_axes.pos[IDX_DEFLECT] = RST_DEFLECT_POS;
		plan_axes.relay_out = RELAY_ALL;
		plan_axes.relay_next = RELAY_ALL;
		seen_axes = plan_axes;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// straight out of reset, default settings
		queue_word(tick_word());                                          // tick while idle
		queue_word(cmd_word(9'd50, 9'd0, 9'd0, ARC_CW, POL_POS));         // all at position
		queue_word(cmd_word(9'd511, 9'd511, 9'd511, ARC_KEEP, POL_KEEP)); // all beyond limit
		queue_word(cmd_word(9'd51, 9'd0, 9'd0, ARC_CCW, POL_NEG));        // short deflect move
		queue_word(cmd_word(9'd0, 9'd250, 9'd300, ARC_OFF, POL_OFF));     // arrives while busy
		tick_until_idle();
		queue_word(tick_word());
		wait_idle();

		// extreme settings: zero scale, full scale, half-unit rounding, limit of zero
		set_regs(16'hFFFF, 16'd0, 16'd128, 9'd511, 9'd0, 9'd511);
		queue_word(cmd_word(9'd0, 9'd1, 9'd1, ARC_OFF, POL_OFF));
		tick_until_idle();
		queue_word(cmd_word(9'd1, 9'd1, 9'd0, ARC_CW, POL_KEEP));
		tick_until_idle();
		wait_idle();

		// random phases, each ending with the sender held until all results are in
		set_regs(SPU_W'($urandom_range(0, 96)), SPU_W'($urandom_range(0, 96)),
			SPU_W'($urandom_range(0, 96)), TGT_W'($urandom_range(0, 511)),
			TGT_W'($urandom_range(0, 511)), TGT_W'($urandom_range(0, 511)));
		random_moves(300);
		wait_idle();

		set_regs(SPU_W'($urandom_range(0, 64)), SPU_W'($urandom_range(0, 64)),
			SPU_W'($urandom_range(0, 64)), 9'd511, 9'd511, 9'd511);
		random_moves(300);
		wait_idle();

		// one steep motor, the others shallow
		set_regs(SPU_W'($urandom_range(1024, 65535)), SPU_W'($urandom_range(0, 96)),
			SPU_W'($urandom_range(0, 96)), TGT_W'($urandom_range(0, 511)),
			TGT_W'($urandom_range(0, 511)), TGT_W'($urandom_range(0, 511)));
		random_moves(300);
		wait_idle();

		set_regs(16'd256, 16'd256, SPU_W'($urandom_range(0, 65535)),
			9'd0, TGT_W'($urandom_range(0, 31)), TGT_W'($urandom_range(0, 31)));
		random_moves(300);
		wait_idle();

		// last stretch runs back at the defaults with no idling on either side
		calm = 1'b1;
		set_regs(RST_ACCEL_SPU, RST_DEFLECT_SPU, RST_MAG_SPU,
			RST_ACCEL_LIMIT, RST_DEFLECT_LIMIT, RST_MAG_LIMIT);
		random_moves(300);
		wait_idle();

		// let any stray result show up
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
